// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by slsd_checker.
// SLSD_ASSERT_CLK names its clock and active-low reset; SLSD_ASSERT uses the
// default i_clk / i_rst_n pair.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SLSD_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SLSD_ASSERT(lbl, prop, msg) \
    `SLSD_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/core/slsd_pkg.sv =====
// ----------------------------------------------------------------------------
// slsd_pkg
// Shared widths and codes for the static linked-list symmetric difference set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slsd_pkg;

    localparam int NODES   = 64;
    localparam int IDX_W   = $clog2(NODES);
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 6;

    // Commands
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TOGGLE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd3;

    // Result status
    localparam logic [STAT_W-1:0] ST_DONE       = 3'd0;
    localparam logic [STAT_W-1:0] ST_INSERTED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_REMOVED    = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL       = 3'd3;
    localparam logic [STAT_W-1:0] ST_DUMP_ELEM  = 3'd4;
    localparam logic [STAT_W-1:0] ST_DUMP_EMPTY = 3'd5;

    // Header node is always the first node taken after a clear.
    localparam logic [IDX_W-1:0] HDR_NODE  = IDX_W'(1);
    localparam logic [IDX_W-1:0] FREE_INIT = IDX_W'(2);

endpackage

`default_nettype wire

// ===== rtl/core/slsd_if.sv =====
// ----------------------------------------------------------------------------
// slsd_in_if / slsd_out_if
// Valid/ready channels for commands in and results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface slsd_in_if import slsd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface slsd_out_if import slsd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [DATA_W-1:0]  element;
    logic [COUNT_W-1:0] count;
    logic               last;

    modport source (output valid, output status, output element, output count,
                    output last, input ready);
    modport sink   (input valid, input status, input element, input count,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/static_list_symmetric_difference.sv =====
// ----------------------------------------------------------------------------
// static_list_symmetric_difference
// Linked-list set in a fixed node store with clear/append/toggle/dump commands.
// ----------------------------------------------------------------------------
// One command is worked on at a time; i_in.ready is high only while idle.
// Each result is held in an output register until its transfer completes.
// Clear goes straight to its result; append steps through S_STOP and
// S_INS0 to S_INS2. Toggle reads the tail link, then walks the A portion
// of the list node by node (link and value memories read together, then
// compared). Dump gives one result per element and reads the next node
// only after the previous result has been taken.
// The walk is bound by the single read port of the link memory.
// Link words start from a reset image through per-entry valid bits, so reset
// and clear need no sweep over the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module static_list_symmetric_difference import slsd_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    slsd_in_if.sink      i_in,
    slsd_out_if.source   o_out
);

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_STOP   = 4'd1;  // tail link arrives
    localparam logic [3:0] S_TLD    = 4'd2;  // header successor arrives
    localparam logic [3:0] S_TCHK   = 4'd3;  // end-of-walk check
    localparam logic [3:0] S_TCMP   = 4'd4;  // value compare
    localparam logic [3:0] S_RM     = 4'd5;  // free found node
    localparam logic [3:0] S_INS0   = 4'd6;  // take free node
    localparam logic [3:0] S_INS1   = 4'd7;  // write value and new link
    localparam logic [3:0] S_INS2   = 4'd8;  // link after tail
    localparam logic [3:0] S_DFIRST = 4'd9;  // first dump link arrives
    localparam logic [3:0] S_DRD    = 4'd10; // issue dump reads
    localparam logic [3:0] S_DEMIT  = 4'd11; // dump element ready
    localparam logic [3:0] S_OUT    = 4'd12; // result waits for transfer

    // Link reset image: i+1, except the header and the final entry
    function automatic logic [IDX_W-1:0] lnk_rst(input logic [IDX_W-1:0] a);
        logic [IDX_W-1:0] v;
        if (a == HDR_NODE || a == IDX_W'(NODES - 1)) begin
            v = '0;
        end else begin
            v = a + IDX_W'(1);
        end
        return v;
    endfunction

    // Node store
    logic [IDX_W-1:0]  lnk_mem [NODES];
    logic [DATA_W-1:0] val_mem [NODES];
    logic [NODES-1:0]  r_lnk_vld;

    logic [IDX_W-1:0]  raddr;
    logic              lnk_we;
    logic [IDX_W-1:0]  lnk_waddr;
    logic [IDX_W-1:0]  lnk_wdata;
    logic              val_we;
    logic              lnk_clr;
    logic [IDX_W-1:0]  r_lnk_rd;
    logic [DATA_W-1:0] r_val_rd;

    // Control
    logic [3:0]         r_state,  n_state;
    logic [3:0]         r_after,  n_after;
    logic [IDX_W-1:0]   r_fh,     n_fh;
    logic [IDX_W-1:0]   r_tail,   n_tail;
    logic [COUNT_W-1:0] r_count,  n_count;
    logic [IDX_W:0]     r_steps,  n_steps;
    logic [IDX_W-1:0]   r_n,      n_n;

    // Working payload
    logic [CMD_W-1:0]   r_cmd,    n_cmd;
    logic [DATA_W-1:0]  r_value,  n_value;
    logic [IDX_W-1:0]   r_stop,   n_stop;
    logic [IDX_W-1:0]   r_k,      n_k;
    logic [IDX_W-1:0]   r_p,      n_p;
    logic [IDX_W-1:0]   r_node,   n_node;
    logic [STAT_W-1:0]  r_status, n_status;
    logic [DATA_W-1:0]  r_elem,   n_elem;
    logic               r_last,   n_last;

    logic               dump_fin;

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = (r_state == S_OUT);
    assign o_out.status  = r_status;
    assign o_out.element = r_elem;
    assign o_out.count   = r_count;
    assign o_out.last    = r_last;

    // Dump stops at end of list or after NODES-2 elements
    assign dump_fin = (r_lnk_rd == '0) || (r_n == IDX_W'(NODES - 3));

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (lnk_we) begin
            lnk_mem[lnk_waddr] <= lnk_wdata;
        end
        if (val_we) begin
            val_mem[r_node] <= r_value;
        end
        r_lnk_rd <= r_lnk_vld[raddr] ? lnk_mem[raddr] : lnk_rst(raddr);
        r_val_rd <= val_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || lnk_clr) begin
            r_lnk_vld <= '0;
        end else if (lnk_we) begin
            r_lnk_vld[lnk_waddr] <= 1'b1;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state  = r_state;
        n_after  = r_after;
        n_fh     = r_fh;
        n_tail   = r_tail;
        n_count  = r_count;
        n_steps  = r_steps;
        n_n      = r_n;
        n_cmd    = r_cmd;
        n_value  = r_value;
        n_stop   = r_stop;
        n_k      = r_k;
        n_p      = r_p;
        n_node   = r_node;
        n_status = r_status;
        n_elem   = r_elem;
        n_last   = r_last;

        raddr     = r_k;
        lnk_we    = 1'b0;
        lnk_waddr = r_node;
        lnk_wdata = r_stop;
        val_we    = 1'b0;
        lnk_clr   = 1'b0;

        case (r_state)
            S_IDLE: begin
                raddr = r_tail;
                if (i_in.valid) begin
                    n_cmd   = i_in.cmd;
                    n_value = i_in.value;
                    n_elem  = '0;
                    n_last  = 1'b1;
                    n_after = S_IDLE;
                    case (i_in.cmd)
                        CMD_CLEAR: begin
                            lnk_clr  = 1'b1;
                            n_fh     = FREE_INIT;
                            n_tail   = HDR_NODE;
                            n_count  = '0;
                            n_status = ST_DONE;
                            n_state  = S_OUT;
                        end
                        CMD_DUMP: begin
                            raddr   = HDR_NODE;
                            n_state = S_DFIRST;
                        end
                        default: begin
                            n_state = S_STOP;
                        end
                    endcase
                end
            end

            S_STOP: begin
                n_stop = r_lnk_rd;
                if (r_cmd == CMD_APPEND) begin
                    n_state = S_INS0;
                end else begin
                    raddr   = HDR_NODE;
                    n_p     = HDR_NODE;
                    n_steps = '0;
                    n_state = S_TLD;
                end
            end

            S_TLD: begin
                n_k     = r_lnk_rd;
                n_state = S_TCHK;
            end

            S_TCHK: begin
                raddr = r_k;
                if (r_k == r_stop || r_k == '0 || r_steps[IDX_W]) begin
                    n_state = S_INS0;
                end else begin
                    n_state = S_TCMP;
                end
            end

            S_TCMP: begin
                if (r_val_rd == r_value) begin
                    // unlink: predecessor skips the match
                    lnk_we    = 1'b1;
                    lnk_waddr = r_p;
                    lnk_wdata = r_lnk_rd;
                    n_state   = S_RM;
                end else begin
                    n_p     = r_k;
                    n_k     = r_lnk_rd;
                    n_steps = r_steps + (IDX_W+1)'(1);
                    n_state = S_TCHK;
                end
            end

            S_RM: begin
                lnk_we    = 1'b1;
                lnk_waddr = r_k;
                lnk_wdata = r_fh;
                n_fh      = r_k;
                if (r_tail == r_k) begin
                    n_tail = r_p;
                end
                if (r_count != '0) begin
                    n_count = r_count - COUNT_W'(1);
                end
                n_status = ST_REMOVED;
                n_state  = S_OUT;
            end

            S_INS0: begin
                raddr  = r_fh;
                n_node = r_fh;
                if (r_fh == '0) begin
                    n_status = ST_FULL;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_INS1;
                end
            end

            S_INS1: begin
                n_fh      = r_lnk_rd;
                val_we    = 1'b1;
                lnk_we    = 1'b1;
                lnk_waddr = r_node;
                lnk_wdata = r_stop;
                n_state   = S_INS2;
            end

            S_INS2: begin
                lnk_we    = 1'b1;
                lnk_waddr = r_tail;
                lnk_wdata = r_node;
                if (r_cmd == CMD_APPEND) begin
                    n_tail = r_node;
                end
                n_count  = r_count + COUNT_W'(1);
                n_status = ST_INSERTED;
                n_state  = S_OUT;
            end

            S_DFIRST: begin
                n_k = r_lnk_rd;
                n_n = '0;
                if (r_lnk_rd == '0) begin
                    n_status = ST_DUMP_EMPTY;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_DRD;
                end
            end

            S_DRD: begin
                raddr   = r_k;
                n_state = S_DEMIT;
            end

            S_DEMIT: begin
                n_status = ST_DUMP_ELEM;
                n_elem   = r_val_rd;
                n_last   = dump_fin;
                n_k      = r_lnk_rd;
                n_n      = r_n + IDX_W'(1);
                n_after  = dump_fin ? S_IDLE : S_DRD;
                n_state  = S_OUT;
            end

            S_OUT: begin
                if (o_out.ready) begin
                    n_state = r_after;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
            r_fh    <= FREE_INIT;
            r_tail  <= HDR_NODE;
            r_count <= '0;
            r_steps <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_fh    <= n_fh;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_steps <= n_steps;
            r_n     <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_value  <= n_value;
        r_stop   <= n_stop;
        r_k      <= n_k;
        r_p      <= n_p;
        r_node   <= n_node;
        r_status <= n_status;
        r_elem   <= n_elem;
        r_last   <= n_last;
    end

endmodule

`default_nettype wire

// ===== rtl/core/slsd_checker.sv =====
// ----------------------------------------------------------------------------
// slsd_checker
// Port-level checks for the list set, bound onto the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module slsd_checker import slsd_pkg::*; (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_valid,
    input wire                i_in_ready,
    input wire                i_out_valid,
    input wire                i_out_ready,
    input wire [STAT_W-1:0]   i_status,
    input wire [DATA_W-1:0]   i_element,
    input wire                i_last
);

    // one command at a time: busy right after a transfer in
    `SLSD_ASSERT(a_busy_after_in, (i_in_valid && i_in_ready) |=> !i_in_ready, "ready after accept")

    // never take a command while a result is pending
    `SLSD_ASSERT(a_no_in_with_out, i_out_valid |-> !i_in_ready, "ready with result pending")

    // only dump elements can be non-final results
    `SLSD_ASSERT(a_last_nondump, (i_out_valid && i_status != ST_DUMP_ELEM) |-> i_last, "missing last")

    // element is zero outside dump elements
    `SLSD_ASSERT(a_elem_zero, (i_out_valid && i_status != ST_DUMP_ELEM) |-> (i_element == '0), "element not zero")

    // a stalled result holds
    `SLSD_ASSERT(a_out_hold, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status)), "result dropped")

endmodule

bind static_list_symmetric_difference slsd_checker u_slsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_element   (o_out.element),
    .i_last      (o_out.last)
);

`default_nettype wire

// ===== tb/sv/static_list_symmetric_difference_tb.sv =====
// ----------------------------------------------------------------------------
// static_list_symmetric_difference_tb
// Self-checking bench for the linked-list set with clear/append/toggle/dump.
// A directed table runs first, then a phase that fills the node store to overflow,
// then random phases. A bench-side list model predicts every result, and each
// output transfer is checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module static_list_symmetric_difference_tb;
    import slsd_pkg::*;

    localparam int ITEM_TARGET = 360;
    localparam int DRAIN_CYCLES = 200;

    // One predicted result, in output field order.
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [DATA_W-1:0]  element;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_list_result;

    // Directed row. Where typed is set, the single result is written out by
    // hand; otherwise the row is checked against the list model.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [DATA_W-1:0]  value;
        logic               typed;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] count;
    } t_directed_row;

    localparam int N_DIRECTED = 21;

    logic i_clk;
    logic i_rst_n;

    slsd_in_if  in_if ();
    slsd_out_if out_if ();

    static_list_symmetric_difference DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // ------------------------------------------------------------------------
    // Clock, reset, watchdog
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Worst case is roughly every command a full 62-entry dump under maximum
    // sink stall; this is several times that.
    initial begin : watchdog
        #25ms;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // List model: node store, free list, header/tail and element count.
    // Node 0 terminates both the list and the free list.
    // ------------------------------------------------------------------------
    logic [IDX_W-1:0]  list_link  [NODES];
    logic [DATA_W-1:0] list_value [NODES];
    logic [IDX_W-1:0]  free_head;
    logic [IDX_W-1:0]  head_node;
    logic [IDX_W-1:0]  tail_node;
    int                elem_count;

    t_list_result results_due [$];

    int err_count = 0;
    int items_fed = 0;
    int results_checked = 0;
    int cmd_seen [4] = '{default: 0};
    int status_seen [8] = '{default: 0};
    bit tx_quick = 1'b0;

    function automatic logic [IDX_W-1:0] grab_node();
        logic [IDX_W-1:0] n;
        n = free_head;
        if (n != '0) begin
            free_head = list_link[n];
        end
        return n;
    endfunction

    // Same image as after reset: free list 1..NODES-1, header takes node 1.
    function automatic void list_clear();
        for (int i = 0; i < NODES; i++) begin
            list_link[i]  = IDX_W'((i + 1) % NODES);
            list_value[i] = '0;
        end
        free_head = IDX_W'(1);
        head_node = grab_node();
        list_link[head_node] = '0;
        tail_node  = head_node;
        elem_count = 0;
    endfunction

    function automatic void expect_result(logic [STAT_W-1:0] st, logic [DATA_W-1:0] el,
                                          logic fin);
        t_list_result r;
        r.status  = st;
        r.element = el;
        r.count   = COUNT_W'(elem_count);
        r.last    = fin;
        results_due.push_back(r);
    endfunction

    // New node goes right behind the tail; append moves the tail onto it,
    // a toggle insert leaves the tail where it is.
    function automatic logic [STAT_W-1:0] link_after_tail(logic [DATA_W-1:0] v,
                                                          bit move_tail);
        logic [IDX_W-1:0] n;
        n = grab_node();
        if (n == '0) begin
            return ST_FULL;
        end
        list_value[n]        = v;
        list_link[n]         = list_link[tail_node];
        list_link[tail_node] = n;
        if (move_tail) begin
            tail_node = n;
        end
        elem_count++;
        return ST_INSERTED;
    endfunction

    function automatic void predict_command(logic [CMD_W-1:0] c, logic [DATA_W-1:0] v);
        logic [IDX_W-1:0] stop;
        logic [IDX_W-1:0] prv;
        logic [IDX_W-1:0] k;
        logic [IDX_W-1:0] nx;
        int               steps;
        int               n;
        case (c)
            CMD_CLEAR: begin
                list_clear();
                expect_result(ST_DONE, '0, 1'b1);
            end
            CMD_APPEND: begin
                expect_result(link_after_tail(v, 1'b1), '0, 1'b1);
            end
            CMD_TOGGLE: begin
                // Search only the A portion: header successor through the tail.
                stop  = list_link[tail_node];
                prv   = head_node;
                k     = list_link[head_node];
                steps = 0;
                while (k != stop && k != '0 && list_value[k] != v && steps < NODES) begin
                    prv = k;
                    k   = list_link[k];
                    steps++;
                end
                if (k == stop || k == '0 || steps >= NODES) begin
                    expect_result(link_after_tail(v, 1'b0), '0, 1'b1);
                end else begin
                    list_link[prv] = list_link[k];
                    list_link[k]   = free_head;
                    free_head      = k;
                    if (tail_node == k) begin
                        tail_node = prv;
                    end
                    if (elem_count > 0) begin
                        elem_count--;
                    end
                    expect_result(ST_REMOVED, '0, 1'b1);
                end
            end
            default: begin
                k = list_link[head_node];
                if (k == '0) begin
                    expect_result(ST_DUMP_EMPTY, '0, 1'b1);
                end else begin
                    n = 0;
                    while (k != '0 && n < NODES - 2) begin
                        nx = list_link[k];
                        expect_result(ST_DUMP_ELEM, list_value[k],
                                      (nx == '0) || (n + 1 >= NODES - 2));
                        n++;
                        k = nx;
                    end
                end
            end
        endcase
    endfunction

    // Random value currently on the list (A or B portion); 0 if list is empty.
    function automatic bit listed_value(output logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] seen [$];
        logic [IDX_W-1:0]  k;
        int                steps;
        k     = list_link[head_node];
        steps = 0;
        v     = '0;
        while (k != '0 && steps < NODES) begin
            seen.push_back(list_value[k]);
            k = list_link[k];
            steps++;
        end
        if (seen.size() == 0) begin
            return 1'b0;
        end
        v = seen[$urandom_range(0, seen.size() - 1)];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Command side. Inputs move on the falling edge; a transfer is seen at
    // the rising edge where ready is high with valid held. Valid is only
    // dropped in a gap or after the last item; back-to-back items keep it high.
    // ------------------------------------------------------------------------
    task automatic feed_command(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] v,
                                input logic typed, input logic [STAT_W-1:0] t_status,
                                input logic [COUNT_W-1:0] t_count);
        int unsigned  gap;
        t_list_result hand;
        gap = tx_quick ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid <= 1'b1;
        in_if.cmd   <= c;
        in_if.value <= v;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        predict_command(c, v);
        if (typed) begin
            // Hand-written expectation replaces the model's single result.
            void'(results_due.pop_back());
            hand.status  = t_status;
            hand.element = '0;
            hand.count   = t_count;
            hand.last    = 1'b1;
            results_due.push_back(hand);
        end
        items_fed++;
        cmd_seen[c]++;
    endtask

    // Edges of the value field, both orders of toggle hit/miss, tail removal
    // stepping back to the header, duplicates, and dumps of empty lists.
    t_directed_row directed_rows [N_DIRECTED] = '{
        '{CMD_DUMP,   32'h0000_0000, 1'b1, ST_DUMP_EMPTY, 6'd0},  // fresh after reset
        '{CMD_TOGGLE, 32'h0000_0000, 1'b1, ST_INSERTED,   6'd1},  // empty A portion
        '{CMD_DUMP,   32'hFFFF_FFFF, 1'b0, ST_DONE,       6'd0},
        '{CMD_APPEND, 32'hFFFF_FFFF, 1'b0, ST_INSERTED,   6'd2},
        '{CMD_TOGGLE, 32'h0000_0000, 1'b0, ST_INSERTED,   6'd3},  // only in B: insert
        '{CMD_TOGGLE, 32'hFFFF_FFFF, 1'b0, ST_REMOVED,    6'd2},  // tail back to header
        '{CMD_DUMP,   32'h0000_0000, 1'b0, ST_DONE,       6'd0},
        '{CMD_APPEND, 32'hAAAA_AAAA, 1'b0, ST_INSERTED,   6'd3},
        '{CMD_APPEND, 32'h5555_5555, 1'b0, ST_INSERTED,   6'd4},
        '{CMD_APPEND, 32'hAAAA_AAAA, 1'b0, ST_INSERTED,   6'd5},  // duplicate
        '{CMD_TOGGLE, 32'hAAAA_AAAA, 1'b0, ST_REMOVED,    6'd4},  // first copy goes
        '{CMD_TOGGLE, 32'h5555_5555, 1'b0, ST_REMOVED,    6'd3},  // header successor
        '{CMD_TOGGLE, 32'h1234_5678, 1'b0, ST_INSERTED,   6'd4},
        '{CMD_DUMP,   32'h0000_0000, 1'b0, ST_DONE,       6'd0},
        '{CMD_CLEAR,  32'h0000_0000, 1'b1, ST_DONE,       6'd0},
        '{CMD_DUMP,   32'h0000_0000, 1'b1, ST_DUMP_EMPTY, 6'd0},
        '{CMD_TOGGLE, 32'h8000_0001, 1'b0, ST_INSERTED,   6'd1},
        '{CMD_APPEND, 32'h7FFF_FFFE, 1'b0, ST_INSERTED,   6'd2},
        '{CMD_TOGGLE, 32'h7FFF_FFFE, 1'b0, ST_REMOVED,    6'd1},
        '{CMD_CLEAR,  32'hFFFF_FFFF, 1'b1, ST_DONE,       6'd0},  // value ignored
        '{CMD_DUMP,   32'h5A5A_5A5A, 1'b1, ST_DUMP_EMPTY, 6'd0}
    };

    initial begin : command_feed
        logic [DATA_W-1:0] pool [6];
        logic [DATA_W-1:0] v;
        logic [CMD_W-1:0]  c;
        int                phase_len;
        int                r;
        int                guard;
        in_if.valid <= 1'b0;
        in_if.cmd   <= CMD_CLEAR;
        in_if.value <= '0;
        list_clear();
        wait (i_rst_n === 1'b1);

        for (int i = 0; i < N_DIRECTED; i++) begin
            feed_command(directed_rows[i].cmd, directed_rows[i].value,
                         directed_rows[i].typed, directed_rows[i].status,
                         directed_rows[i].count);
        end

        // Fill the store to overflow, dump it whole, then strip it back down.
        feed_command(CMD_CLEAR, $urandom(), 1'b0, ST_DONE, '0);
        guard = 0;
        while (elem_count < NODES - 2 && guard < 2 * NODES) begin
            c = ($urandom_range(0, 1) == 0) ? CMD_APPEND : CMD_TOGGLE;
            feed_command(c, $urandom(), 1'b0, ST_DONE, '0);
            guard++;
        end
        feed_command(CMD_DUMP, $urandom(), 1'b0, ST_DONE, '0);
        feed_command(CMD_APPEND, $urandom(), 1'b0, ST_DONE, '0);
        feed_command(CMD_TOGGLE, $urandom(), 1'b0, ST_DONE, '0);
        repeat (30) begin
            if (!listed_value(v)) begin
                v = $urandom();
            end
            feed_command(CMD_TOGGLE, v, 1'b0, ST_DONE, '0);
        end

        // Random phases: a small value pool per phase so toggles hit both the
        // A and B portions, plus values pulled off the live list.
        while (items_fed < ITEM_TARGET) begin
            foreach (pool[j]) begin
                pool[j] = $urandom();
            end
            tx_quick  = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(10, 40);
            if ($urandom_range(0, 5) == 0) begin
                feed_command(CMD_CLEAR, $urandom(), 1'b0, ST_DONE, '0);
            end
            repeat (phase_len) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    c = CMD_CLEAR;
                end else if (r < 35) begin
                    c = CMD_APPEND;
                end else if (r < 85) begin
                    c = CMD_TOGGLE;
                end else begin
                    c = CMD_DUMP;
                end
                r = $urandom_range(0, 99);
                if (c == CMD_TOGGLE && r < 55) begin
                    if (!listed_value(v)) begin
                        v = pool[$urandom_range(0, 5)];
                    end
                end else if ((c == CMD_TOGGLE || c == CMD_APPEND) && r < 80) begin
                    v = pool[$urandom_range(0, 5)];
                end else begin
                    v = $urandom();
                end
                feed_command(c, v, 1'b0, ST_DONE, '0);
            end
        end

        @(negedge i_clk);
        in_if.valid <= 1'b0;

        // Wait out the remaining results, then give the block time to show
        // anything spurious.
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d commands (clear %0d, append %0d, toggle %0d, dump %0d), %0d %s",
                 items_fed, cmd_seen[CMD_CLEAR], cmd_seen[CMD_APPEND],
                 cmd_seen[CMD_TOGGLE], cmd_seen[CMD_DUMP], results_checked, "results");
        $display("results seen: done %0d, inserted %0d, removed %0d, full %0d, %s %0d, %s %0d",
                 status_seen[ST_DONE], status_seen[ST_INSERTED], status_seen[ST_REMOVED],
                 status_seen[ST_FULL], "element", status_seen[ST_DUMP_ELEM],
                 "empty", status_seen[ST_DUMP_EMPTY]);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side. Ready moves on the falling edge after a per-transfer hold
    // drawn here; every so often the hold is a long stall so the block backs
    // up and stops taking commands. Checks happen at the rising edge.
    // ------------------------------------------------------------------------
    initial begin : result_drain
        int unsigned  hold_off;
        int unsigned  rx_count;
        bit           rx_quick;
        t_list_result want;
        hold_off = 0;
        rx_count = 0;
        rx_quick = 1'b0;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_off != 0) begin
                out_if.ready <= 1'b0;
                hold_off--;
            end else begin
                out_if.ready <= 1'b1;
            end
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                results_checked++;
                status_seen[out_if.status]++;
                if (results_due.size() == 0) begin
                    $error("result with nothing expected: status %0d element %0h",
                           out_if.status, out_if.element);
                    err_count++;
                end else begin
                    want = results_due.pop_front();
                    if (out_if.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, out_if.status);
                        err_count++;
                    end
                    if (out_if.element !== want.element) begin
                        $error("element mismatch: expected %0h, got %0h",
                               want.element, out_if.element);
                        err_count++;
                    end
                    if (out_if.count !== want.count) begin
                        $error("count mismatch: expected %0d, got %0d",
                               want.count, out_if.count);
                        err_count++;
                    end
                    if (out_if.last !== want.last) begin
                        $error("last mismatch: expected %0b, got %0b",
                               want.last, out_if.last);
                        err_count++;
                    end
                end
                rx_count++;
                if (rx_count % 40 == 0) begin
                    rx_quick = ($urandom_range(0, 3) == 0);
                end
                if (rx_count % 400 == 120) begin
                    hold_off = 300;
                end else begin
                    hold_off = rx_quick ? 0 : $urandom_range(0, 14);
                end
            end
        end
    end

endmodule
